### hw/rtl/modexp_pkg.sv
// Package for the modular exponentiation block: field widths, step counts,
// multiplier request/response structs and sequencer state codes.
// No dependencies; imported by every module of the block.
package modexp_pkg;

  localparam int MOD_W   = 31;
  localparam int BASE_W  = 32;
  localparam int EXP_W   = 32;
  localparam int SUM_W   = MOD_W + 1;
  localparam int MUL_STEPS = BASE_W;
  localparam int CNT_W   = $clog2(MUL_STEPS);

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(23);
  localparam logic [MOD_W-1:0] MOD_ONE   = MOD_W'(1);

  typedef struct packed {
    logic              start;
    logic [BASE_W-1:0] opa;
    logic [MOD_W-1:0]  opb;
    logic [MOD_W-1:0]  modulus;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] result;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REDUCE = 4'b0010,
    S_MUL    = 4'b0100,
    S_SQR    = 4'b1000
  } state_e;

endpackage

### hw/rtl/modexp_mulser.sv
// Bit-serial interleaved modular multiplier: opa * opb mod modulus.
// Depends on modexp_pkg for widths and the request/response structs.
module modexp_mulser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  modexp_pkg::mul_req_t req_i,
  output modexp_pkg::mul_rsp_t rsp_o
);
  import modexp_pkg::*;

  logic [BASE_W-1:0] a_q, a_d;
  logic [MOD_W-1:0]  b_q, b_d;
  logic [MOD_W-1:0]  m_q, m_d;
  logic [MOD_W-1:0]  r_q, r_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [MOD_W-1:0]  res_q, res_d;

  logic [SUM_W-1:0] dbl, dbl_red, sum, sum_red, m_ext;
  logic [MOD_W-1:0] step_r;

  // One step: r = (2r + a_msb * b) mod m, with r < m kept between steps, so
  // each of the two partial results needs at most one subtraction.
  always_comb begin
    m_ext   = {1'b0, m_q};
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum     = dbl_red + (a_q[BASE_W-1] ? {1'b0, b_q} : '0);
    sum_red = (sum >= m_ext) ? sum - m_ext : sum;
    step_r  = sum_red[MOD_W-1:0];
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    res_d  = res_q;
    if (req_i.start) begin
      a_d   = req_i.opa;
      b_d   = req_i.opb;
      m_d   = req_i.modulus;
      r_d   = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      a_d   = {a_q[BASE_W-2:0], 1'b0};
      r_d   = step_r;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
        res_d  = step_r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    m_q   <= m_d;
    r_q   <= r_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

### hw/rtl/modular_exponentiation.sv
// Modular exponentiation top level; uses modexp_pkg and the modexp_mulser multiplier.
// Each modular multiplication is a launch, 32 serial steps and a response; the multiplications are
// the base reduction, one square per bit below the top set bit and one multiply per set bit.
// An all-ones exponent needs 64 of them.
// Items are taken one at a time, a new start only while idle; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) idles the block and sets the modulus to 23.
module modular_exponentiation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [modexp_pkg::MOD_W-1:0]  cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [modexp_pkg::BASE_W-1:0] base_value_i,
  input  logic [modexp_pkg::EXP_W-1:0]  exponent_value_i,
  output logic                          done_o,
  output logic [modexp_pkg::MOD_W-1:0]  power_residue_o
);
  import modexp_pkg::*;

  // All arithmetic runs on a single bit-serial modular multiplier. The
  // sequencer first reduces the base by multiplying it by one, then walks
  // the exponent from its least significant bit: a set bit multiplies the
  // accumulator by the current base, and the base is squared before moving
  // to the next bit. The walk stops as soon as no set bits remain.

  state_e state_q, state_d;

  logic [MOD_W-1:0]  modulus_q;
  logic [MOD_W-1:0]  m_q, m_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic [MOD_W-1:0]  acc_q, acc_d;
  logic [EXP_W-1:0]  exp_q, exp_d;
  logic [EXP_W-1:0]  exp_next;
  logic              launch_q, launch_d;
  logic              done_q, done_d;
  logic [MOD_W-1:0]  res_q, res_d;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // The configuration register is expected to be written only while the
  // block is idle; the modulus is copied at the start transfer anyway.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_RESET;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign exp_next = exp_q >> 1;

  always_comb begin
    state_d  = state_q;
    m_d      = m_q;
    base_d   = base_q;
    acc_d    = acc_q;
    exp_d    = exp_q;
    launch_d = 1'b0;
    done_d   = 1'b0;
    res_d    = res_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          base_d   = base_value_i;
          exp_d    = exponent_value_i;
          // A zero modulus behaves as a modulus of one.
          m_d      = (modulus_q == '0) ? MOD_ONE : modulus_q;
          acc_d    = MOD_ONE;
          launch_d = 1'b1;
          state_d  = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (mul_rsp.done) begin
          base_d = {1'b0, mul_rsp.result};
          if (exp_q == '0) begin
            // Exponent zero returns one unreduced, even for modulus one.
            done_d  = 1'b1;
            res_d   = acc_q;
            state_d = S_IDLE;
          end else begin
            launch_d = 1'b1;
            state_d  = exp_q[0] ? S_MUL : S_SQR;
          end
        end
      end
      S_MUL: begin
        if (mul_rsp.done) begin
          acc_d = mul_rsp.result;
          if (exp_next == '0) begin
            // The final square would never be used, so it is skipped.
            done_d  = 1'b1;
            res_d   = mul_rsp.result;
            state_d = S_IDLE;
          end else begin
            launch_d = 1'b1;
            state_d  = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mul_rsp.done) begin
          // A square is only issued when set bits remain above this one.
          base_d   = {1'b0, mul_rsp.result};
          exp_d    = exp_next;
          launch_d = 1'b1;
          state_d  = exp_next[0] ? S_MUL : S_SQR;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Operands are picked by the state that the multiplier was launched in;
  // they are held stable for the whole multiplication.
  always_comb begin
    mul_req.start   = launch_q;
    mul_req.modulus = m_q;
    case (state_q)
      S_REDUCE: begin
        mul_req.opa = base_q;
        mul_req.opb = MOD_ONE;
      end
      S_MUL: begin
        mul_req.opa = {1'b0, acc_q};
        mul_req.opb = base_q[MOD_W-1:0];
      end
      S_SQR: begin
        mul_req.opa = base_q;
        mul_req.opb = base_q[MOD_W-1:0];
      end
      default: begin
        mul_req.opa = base_q;
        mul_req.opb = base_q[MOD_W-1:0];
      end
    endcase
  end

  modexp_mulser u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    exp_q  <= exp_d;
    res_q  <= res_d;
  end

  // Each result transfer lasts exactly one cycle; the receiver cannot stall.
  assign done_o          = done_q;
  assign power_residue_o = res_q;

endmodule

### hw/rtl/modexp_chk.sv
// Port-level checker for the modular exponentiation block and its bind.
// Depends on modexp_pkg for field widths.
module modexp_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [modexp_pkg::MOD_W-1:0] power_residue_o
);
  import modexp_pkg::*;

  // A result is only presented once the block has returned to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted item always makes the block busy.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // Leaving busy always comes with the result transfer.
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("work ended without a result");

  // One result per item: strobes never come back to back.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("repeated result strobe");

  // The residue carries known data whenever it is strobed.
  a_res_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(power_residue_o))
    else $error("unknown residue on result strobe");

endmodule

bind modular_exponentiation modexp_chk u_modexp_chk (.*);
